// ===== hw/rtl/bdsg_pkg.sv =====
`timescale 1ns / 1ps
package bdsg_pkg;

    // Canvas geometry and brush limit
    localparam int CANVAS_WIDTH  = 320;
    localparam int CANVAS_HEIGHT = 200;
    localparam int MAX_RADIUS    = 4;

    // Fixed field widths
    localparam int COORD_W = 12;
    localparam int PIX_X_W = 9;
    localparam int PIX_Y_W = 8;
    localparam int ADDR_W  = 16;
    localparam int COLOR_W = 24;
    localparam int RAD_W   = 3;

    // Derived widths
    localparam int CX_W  = $clog2(CANVAS_WIDTH);
    localparam int CY_W  = $clog2(CANVAS_HEIGHT);
    localparam int OFF_W = $clog2(MAX_RADIUS + 1) + 1;
    localparam int SQ_W  = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Register reset values
    localparam logic               RST_ENABLED = 1'b1;
    localparam logic [COORD_W-1:0] RST_LEFT    = COORD_W'(190);
    localparam logic [COORD_W-1:0] RST_TOP     = COORD_W'(134);
    localparam logic [RAD_W-1:0]   RST_RADIUS  = RAD_W'(2);
    localparam logic [COLOR_W-1:0] RST_COLOR   = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_LEFT   = 3'd1,
        REG_TOP    = 3'd2,
        REG_RADIUS = 3'd3,
        REG_COLOR  = 3'd4
    } t_reg_idx;

    // One stamp to be scanned
    typedef struct packed {
        logic [CX_W-1:0]    cx;
        logic [CY_W-1:0]    cy;
        logic [OFF_W-1:0]   rad;
        logic [SQ_W-1:0]    rad_sq;
        logic [COLOR_W-1:0] color;
    } t_cmd;

endpackage

// ===== hw/rtl/bdsg_in_if.sv =====
`timescale 1ns / 1ps
interface bdsg_in_if import bdsg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] mouse_x;
    logic [COORD_W-1:0] mouse_y;
    logic               button_down;

    modport source (output valid, output mouse_x, output mouse_y, output button_down,
                    input ready);
    modport sink   (input valid, input mouse_x, input mouse_y, input button_down,
                    output ready);
endinterface

// ===== hw/rtl/bdsg_out_if.sv =====
`timescale 1ns / 1ps
interface bdsg_out_if import bdsg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_address,
                    output pixel_color, output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_address,
                    input pixel_color, input last_pixel, output ready);
endinterface

// ===== hw/rtl/brush_disc_stamp_generator.sv =====
`timescale 1ns / 1ps
// Brush disc stamp generator. Each pointer event is mapped to canvas
// coordinates; when enabled, with the button held and the point on the canvas,
// the block emits one pixel write per disc pixel (row-major, off-canvas pixels
// clipped), the last one flagged by last_pixel. The front takes one event per
// cycle while the queue has room and drops events that draw nothing; stamps wait
// in a two-entry queue. The back loads a stamp, scans the (2r+1) x (2r+1) offset
// square at one offset per cycle while the pixel sink does not stall it, then
// flushes the final pixel.
module brush_disc_stamp_generator import bdsg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bdsg_in_if.sink               i_evt,
    bdsg_out_if.source            o_pix
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_cmd_in;
    t_cmd q_cmd_out;

    bdsg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_evt      (i_evt),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_cmd_in)
    );

    bdsg_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd_out)
    );

    bdsg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_cmd_out),
        .o_q_pop   (q_pop),
        .o_pix     (o_pix)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("stamp pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("stamp popped from empty queue");

    a_button_up_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.valid && i_evt.ready && !i_evt.button_down) |-> !q_push)
        else $error("event with button up queued a stamp");
`endif

endmodule

// ===== hw/rtl/bdsg_front.sv =====
`timescale 1ns / 1ps
module bdsg_front import bdsg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bdsg_in_if.sink               i_evt,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_cmd                  o_q_cmd
);

    logic               r_enabled;
    logic [COORD_W-1:0] r_left;
    logic [COORD_W-1:0] r_top;
    logic [RAD_W-1:0]   r_radius;
    logic [COLOR_W-1:0] r_color;

    logic [COORD_W:0]   cx_d;
    logic [COORD_W:0]   cy_d;
    logic               on_canvas;
    logic               stamp;
    logic [OFF_W-1:0]   rad_eff;
    logic [RAD_W-1:0]   rad_wr;

    // Saturate radius writes at the maximum
    assign rad_wr = (i_cfg_data[RAD_W-1:0] > RAD_W'(MAX_RADIUS)) ?
                    RAD_W'(MAX_RADIUS) : i_cfg_data[RAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= RST_ENABLED;
            r_left    <= RST_LEFT;
            r_top     <= RST_TOP;
            r_radius  <= RST_RADIUS;
            r_color   <= RST_COLOR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE: r_enabled <= i_cfg_data[0];
                REG_LEFT:   r_left    <= i_cfg_data[COORD_W-1:0];
                REG_TOP:    r_top     <= i_cfg_data[COORD_W-1:0];
                REG_RADIUS: r_radius  <= rad_wr;
                REG_COLOR:  r_color   <= i_cfg_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cx_d = {1'b0, i_evt.mouse_x} - {1'b0, r_left};
    assign cy_d = {1'b0, i_evt.mouse_y} - {1'b0, r_top};

    assign on_canvas = !cx_d[COORD_W] && (cx_d[COORD_W-1:0] < COORD_W'(CANVAS_WIDTH)) &&
                       !cy_d[COORD_W] && (cy_d[COORD_W-1:0] < COORD_W'(CANVAS_HEIGHT));

    assign stamp = r_enabled && on_canvas && i_evt.button_down;

    // Radius zero acts as one
    assign rad_eff = (r_radius == '0) ? OFF_W'(1) : OFF_W'(r_radius);

    // Drop events that stamp nothing; queue the rest
    assign i_evt.ready = !i_q_full;
    assign o_q_push    = i_evt.valid && !i_q_full && stamp;

    assign o_q_cmd.cx     = cx_d[CX_W-1:0];
    assign o_q_cmd.cy     = cy_d[CY_W-1:0];
    assign o_q_cmd.rad    = rad_eff;
    assign o_q_cmd.rad_sq = SQ_W'(rad_eff) * SQ_W'(rad_eff);
    assign o_q_cmd.color  = r_color;

endmodule

// ===== hw/rtl/bdsg_cmd_fifo.sv =====
`timescale 1ns / 1ps
module bdsg_cmd_fifo import bdsg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/bdsg_back.sv =====
`timescale 1ns / 1ps
module bdsg_back import bdsg_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  t_cmd          i_q_cmd,
    output logic          o_q_pop,
    bdsg_out_if.source    o_pix
);

    localparam int PX_W  = CX_W + 2;
    localparam int PY_W  = CY_W + 2;
    localparam int AF_W  = CX_W + CY_W;
    localparam int DST_W = 2 * OFF_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    typedef struct packed {
        logic [PIX_X_W-1:0] x;
        logic [PIX_Y_W-1:0] y;
        logic [ADDR_W-1:0]  addr;
    } t_pix;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic signed [OFF_W-1:0] r_dx;
    logic signed [OFF_W-1:0] r_dy;

    logic   r_hold_v, n_hold_v;
    t_pix   r_hold;
    logic   r_out_v;
    t_pix   r_out;
    logic   r_out_last;
    logic [COLOR_W-1:0] r_out_color;

    logic [PX_W-1:0]      px;
    logic [PY_W-1:0]      py;
    logic signed [2*OFF_W-1:0] dx_ext;
    logic signed [2*OFF_W-1:0] dy_ext;
    logic [2*OFF_W-1:0]   sq_x;
    logic [2*OFF_W-1:0]   sq_y;
    logic [DST_W-1:0]     dist_sq;
    logic [AF_W-1:0]      addr_full;
    logic signed [OFF_W-1:0] rad_s;
    logic                 px_ok, py_ok, disc_ok, hit;
    logic                 row_end, scan_end, out_free, step;
    logic                 out_load, out_last, hold_load;
    t_pix                 cand;

    assign rad_s = $signed(r_cmd.rad);

    // Candidate pixel at the current offset
    assign px = {2'b00, r_cmd.cx} + {{(PX_W - OFF_W){r_dx[OFF_W-1]}}, r_dx};
    assign py = {2'b00, r_cmd.cy} + {{(PY_W - OFF_W){r_dy[OFF_W-1]}}, r_dy};
    assign px_ok = !px[PX_W-1] && (px < PX_W'(CANVAS_WIDTH));
    assign py_ok = !py[PY_W-1] && (py < PY_W'(CANVAS_HEIGHT));

    assign dx_ext  = {{OFF_W{r_dx[OFF_W-1]}}, r_dx};
    assign dy_ext  = {{OFF_W{r_dy[OFF_W-1]}}, r_dy};
    assign sq_x    = dx_ext * dx_ext;
    assign sq_y    = dy_ext * dy_ext;
    assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
    assign disc_ok = dist_sq <= DST_W'(r_cmd.rad_sq);
    assign hit     = px_ok && py_ok && disc_ok;

    assign addr_full = AF_W'(py[CY_W-1:0]) * AF_W'(CANVAS_WIDTH) + AF_W'(px[CX_W-1:0]);
    assign cand.x    = PIX_X_W'(px[CX_W-1:0]);
    assign cand.y    = PIX_Y_W'(py[CY_W-1:0]);
    assign cand.addr = ADDR_W'(addr_full);

    assign row_end  = (r_dx == rad_s);
    assign scan_end = row_end && (r_dy == rad_s);
    assign out_free = !r_out_v || o_pix.ready;
    // Stall only when a hit must push the held pixel into a full output
    assign step     = !hit || !r_hold_v || out_free;

    always_comb begin
        n_state   = r_state;
        n_hold_v  = r_hold_v;
        o_q_pop   = 1'b0;
        out_load  = 1'b0;
        out_last  = 1'b0;
        hold_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step) begin
                    if (hit) begin
                        out_load  = r_hold_v;
                        hold_load = 1'b1;
                        n_hold_v  = 1'b1;
                    end
                    if (scan_end) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                // The held pixel is the final write of the stamp
                if (!r_hold_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    n_hold_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hold_v <= n_hold_v;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
            r_dx  <= -$signed(i_q_cmd.rad);
            r_dy  <= -$signed(i_q_cmd.rad);
        end else if (r_state == ST_SCAN && step) begin
            if (row_end) begin
                r_dx <= -rad_s;
                r_dy <= r_dy + 1'b1;
            end else begin
                r_dx <= r_dx + 1'b1;
            end
        end
        if (hold_load) begin
            r_hold <= cand;
        end
        if (out_load) begin
            r_out       <= r_hold;
            r_out_last  <= out_last;
            r_out_color <= r_cmd.color;
        end
    end

    assign o_pix.valid         = r_out_v;
    assign o_pix.pixel_x       = r_out.x;
    assign o_pix.pixel_y       = r_out.y;
    assign o_pix.pixel_address = r_out.addr;
    assign o_pix.pixel_color   = r_out_color;
    assign o_pix.last_pixel    = r_out_last;

endmodule

// ===== tb/bdsg_stamp_checker.sv =====
`timescale 1ns / 1ps
module bdsg_stamp_checker import bdsg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bdsg_in_if                    i_evt,
    bdsg_out_if                   i_pix,
    output int                    o_mismatches,
    output int                    o_pixels_owed
);

    typedef struct packed {
        logic [PIX_X_W-1:0] x;
        logic [PIX_Y_W-1:0] y;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel_write;

    // Register copies as the block should hold them
    logic               enabled_q;
    logic [COORD_W-1:0] left_q;
    logic [COORD_W-1:0] top_q;
    logic [RAD_W-1:0]   radius_q;
    logic [COLOR_W-1:0] color_q;

    t_pixel_write pixels_owed[$];
    int           mismatches = 0;

    // Queue the disc of writes that one pointer event should produce.
    function automatic void stamp_disc(input logic [COORD_W-1:0] mx,
                                       input logic [COORD_W-1:0] my,
                                       input logic down);
        int           cx;
        int           cy;
        int           r;
        int           px;
        int           py;
        t_pixel_write pw;
        t_pixel_write stamp[$];
        if (!enabled_q || !down) return;
        cx = int'(mx) - int'(left_q);
        cy = int'(my) - int'(top_q);
        if (cx < 0 || cx >= CANVAS_WIDTH || cy < 0 || cy >= CANVAS_HEIGHT) return;
        r = int'(radius_q);
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        if (r < 1) r = 1;
        for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
                px = cx + dx;
                py = cy + dy;
                if (px < 0 || px >= CANVAS_WIDTH || py < 0 || py >= CANVAS_HEIGHT) continue;
                if (dx * dx + dy * dy > r * r) continue;
                pw.x     = PIX_X_W'(px);
                pw.y     = PIX_Y_W'(py);
                pw.addr  = ADDR_W'(py * CANVAS_WIDTH + px);
                pw.color = color_q;
                pw.last  = 1'b0;
                stamp.push_back(pw);
            end
        end
        // the center is on the canvas, so the stamp is never empty
        stamp[stamp.size() - 1].last = 1'b1;
        foreach (stamp[i]) pixels_owed.push_back(stamp[i]);
    endfunction

    always @(posedge i_clk) begin
        t_pixel_write got;
        t_pixel_write want;
        if (!i_rst_n) begin
            enabled_q = RST_ENABLED;
            left_q    = RST_LEFT;
            top_q     = RST_TOP;
            radius_q  = RST_RADIUS;
            color_q   = RST_COLOR;
            pixels_owed.delete();
        end else begin
            // predict with the settings in force before any write at this edge
            if (i_evt.valid && i_evt.ready)
                stamp_disc(i_evt.mouse_x, i_evt.mouse_y, i_evt.button_down);
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_ENABLE: enabled_q = i_cfg_data[0];
                    REG_LEFT:   left_q    = i_cfg_data[COORD_W-1:0];
                    REG_TOP:    top_q     = i_cfg_data[COORD_W-1:0];
                    REG_RADIUS: begin
                        if (i_cfg_data[RAD_W-1:0] > MAX_RADIUS) radius_q = RAD_W'(MAX_RADIUS);
                        else radius_q = i_cfg_data[RAD_W-1:0];
                    end
                    REG_COLOR:  color_q   = i_cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                got = '{i_pix.pixel_x, i_pix.pixel_y, i_pix.pixel_address,
                        i_pix.pixel_color, i_pix.last_pixel};
                if (pixels_owed.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel write: x=%0d y=%0d addr=%0d color=%06h last=%0b",
                                 got.x, got.y, got.addr, got.color, got.last);
                end else begin
                    want = pixels_owed.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.addr !== want.addr ||
                        got.color !== want.color || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel write mismatch: expected x=%0d y=%0d addr=%0d ",
                                     want.x, want.y, want.addr,
                                     "color=%06h last=%0b, got x=%0d y=%0d addr=%0d ",
                                     want.color, want.last, got.x, got.y, got.addr,
                                     "color=%06h last=%0b",
                                     got.color, got.last);
                    end
                end
            end
        end
        o_mismatches  = mismatches;
        o_pixels_owed = pixels_owed.size();
    end

endmodule

// ===== tb/tb_brush_disc_stamp_generator.sv =====
`timescale 1ns / 1ps
module tb_brush_disc_stamp_generator;
    import bdsg_pkg::*;

    localparam int SETTLE_CYCLES  = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int STAMP_TARGET   = 190;
    localparam int QUIET_ITEMS    = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bdsg_in_if  evt_if ();
    bdsg_out_if pix_if ();

    int mismatches;
    int pixels_owed;
    bit idle_on      = 1'b1;
    int stall_left   = 0;
    int quiet_cycles = 0;

    // What the stimulus believes the canvas settings are, for aiming events
    logic en_now   = RST_ENABLED;
    int   left_now = RST_LEFT;
    int   top_now  = RST_TOP;
    int   stamps_sent = 0;

    brush_disc_stamp_generator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_evt      (evt_if),
        .o_pix      (pix_if)
    );

    bdsg_stamp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_evt         (evt_if),
        .i_pix         (pix_if),
        .o_mismatches  (mismatches),
        .o_pixels_owed (pixels_owed)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Pixel sink: stalls in random bursts, started only while idling is on
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            pix_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            pix_if.ready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            pix_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (evt_if.valid && evt_if.ready) || (pix_if.valid && pix_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Hold off until every pixel is out and the scanner has run dry.
    task automatic drain_pixels();
        evt_if.valid <= 1'b0;
        while (pixels_owed != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_canvas(input logic en, input int left, input int top_row,
                              input int radius, input int color);
        drain_pixels();
        write_reg(REG_ENABLE, CFG_DATA_W'(en));
        write_reg(REG_LEFT, CFG_DATA_W'(left));
        write_reg(REG_TOP, CFG_DATA_W'(top_row));
        write_reg(REG_RADIUS, CFG_DATA_W'(radius));
        write_reg(REG_COLOR, CFG_DATA_W'(color));
        en_now   = en;
        left_now = left;
        top_now  = top_row;
    endtask

    task automatic send_event(input logic [COORD_W-1:0] mx, input logic [COORD_W-1:0] my,
                              input logic down);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            evt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        evt_if.valid       <= 1'b1;
        evt_if.mouse_x     <= mx;
        evt_if.mouse_y     <= my;
        evt_if.button_down <= down;
        @(posedge i_clk);
        while (!evt_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Send an event at a canvas position relative to the current origin.
    task automatic aim(input int cx, input int cy, input logic down);
        send_event(COORD_W'(left_now + cx), COORD_W'(top_now + cy), down);
    endtask

    // Favor positions near the borders so clipping gets exercised.
    function automatic int pick_coord(input int limit);
        case ($urandom_range(0, 2))
            0:       return $urandom_range(0, 4);
            1:       return limit - 1 - $urandom_range(0, 4);
            default: return $urandom_range(0, limit - 1);
        endcase
    endfunction

    task automatic random_event();
        int kind;
        int cx;
        int cy;
        int gap;
        kind = $urandom_range(0, 9);
        cx   = pick_coord(CANVAS_WIDTH);
        cy   = pick_coord(CANVAS_HEIGHT);
        gap  = $urandom_range(0, 3);
        if (kind < 7) begin
            aim(cx, cy, 1'b1);
            if (en_now) stamps_sent++;
        end else if (kind == 7) begin
            aim(cx, cy, 1'b0);
        end else if (kind == 8) begin
            // just off one of the four borders
            case ($urandom_range(0, 3))
                0:       aim(-1 - gap, cy, 1'b1);
                1:       aim(CANVAS_WIDTH + gap, cy, 1'b1);
                2:       aim(cx, -1 - gap, 1'b1);
                default: aim(cx, CANVAS_HEIGHT + gap, 1'b1);
            endcase
        end else begin
            send_event(COORD_W'($urandom()), COORD_W'($urandom()), 1'($urandom()));
        end
    endtask

    task automatic random_canvas();
        int left;
        int top_row;
        if ($urandom_range(0, 3) == 0) left = $urandom_range(0, 4095);
        else left = $urandom_range(0, 4095 - CANVAS_WIDTH);
        if ($urandom_range(0, 3) == 0) top_row = $urandom_range(0, 4095);
        else top_row = $urandom_range(0, 4095 - CANVAS_HEIGHT);
        set_canvas($urandom_range(0, 7) != 0, left, top_row, $urandom_range(0, 7),
                   $urandom_range(0, 24'hFFFFFF));
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        evt_if.valid       = 1'b0;
        evt_if.mouse_x     = '0;
        evt_if.mouse_y     = '0;
        evt_if.button_down = 1'b0;
        pix_if.ready       = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: center, corners, button up, each border, screen extremes
        aim(CANVAS_WIDTH / 2, CANVAS_HEIGHT / 2, 1'b1);
        aim(0, 0, 1'b1);
        aim(CANVAS_WIDTH - 1, CANVAS_HEIGHT - 1, 1'b1);
        aim(CANVAS_WIDTH / 2, CANVAS_HEIGHT / 2, 1'b0);
        aim(-1, CANVAS_HEIGHT / 2, 1'b1);
        aim(CANVAS_WIDTH / 2, -1, 1'b1);
        aim(CANVAS_WIDTH, CANVAS_HEIGHT / 2, 1'b1);
        aim(CANVAS_WIDTH / 2, CANVAS_HEIGHT, 1'b1);
        send_event('0, '0, 1'b1);
        send_event('1, '1, 1'b1);

        // Radius zero acts as one
        set_canvas(1'b1, 0, 0, 0, 24'hFFFFFF);
        aim(0, 0, 1'b1);
        aim(CANVAS_WIDTH - 1, CANVAS_HEIGHT - 1, 1'b1);
        send_event('1, '1, 1'b0);
        aim(1, CANVAS_HEIGHT - 2, 1'b1);

        // Oversized radius saturates
        set_canvas(1'b1, 0, 0, 7, 24'h5A5A5A);
        aim(0, 0, 1'b1);
        aim(CANVAS_WIDTH - 1, 0, 1'b1);
        aim(0, CANVAS_HEIGHT - 1, 1'b1);
        aim(CANVAS_WIDTH / 2, CANVAS_HEIGHT / 2, 1'b1);
        aim(3, 3, 1'b1);

        // Disabled: everything dropped
        set_canvas(1'b0, 0, 0, 3, 24'h123456);
        aim(CANVAS_WIDTH / 2, CANVAS_HEIGHT / 2, 1'b1);
        aim(CANVAS_WIDTH / 2, CANVAS_HEIGHT / 2, 1'b0);

        // Origin at the far screen corner
        set_canvas(1'b1, 4095, 4095, 1, 24'hFFFFFF);
        send_event('1, '1, 1'b1);
        send_event('0, '0, 1'b1);

        // Writes to unused indexes must leave the registers alone
        set_canvas(1'b1, 4095 - (CANVAS_WIDTH - 1), 4095 - (CANVAS_HEIGHT - 1), 6, 24'hC0FFEE);
        for (int k = int'(REG_COLOR) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom()));
        send_event('1, '1, 1'b1);
        aim(100, 50, 1'b1);

        while (stamps_sent < STAMP_TARGET - QUIET_ITEMS) begin
            random_canvas();
            repeat ($urandom_range(20, 40)) random_event();
        end

        // Closing stretch without any idling
        set_canvas(1'b1, $urandom_range(0, 4095 - CANVAS_WIDTH),
                   $urandom_range(0, 4095 - CANVAS_HEIGHT), $urandom_range(0, 7),
                   $urandom_range(0, 24'hFFFFFF));
        idle_on = 1'b0;
        repeat (QUIET_ITEMS) random_event();

        drain_pixels();
        if (mismatches == 0 && pixels_owed == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
